>>> hw/rtl/rc4_pkg.sv
package rc4_pkg;

    localparam int KEY_BYTES = 256;
    localparam int SBOX_SIZE = 256;
    localparam int BYTE_W    = 8;
    localparam int ADDR_W    = $clog2(SBOX_SIZE);
    localparam int KEY_CNT_W = $clog2(SBOX_SIZE + 1);

    typedef enum logic [8:0] {
        ST_INIT = 9'b000000001,
        ST_IDLE = 9'b000000010,
        ST_DJ   = 9'b000000100,
        ST_DSW  = 9'b000001000,
        ST_DKS  = 9'b000010000,
        ST_M0   = 9'b000100000,
        ST_M1   = 9'b001000000,
        ST_M2   = 9'b010000000,
        ST_M3   = 9'b100000000
    } rc4_state_t;

    typedef struct packed {
        logic init_step;
        logic key_accept;
        logic sched_start;
        logic data_accept;
        logic data_rd_j;
        logic data_swap;
        logic data_ks;
        logic data_fin;
        logic mix_rd;
        logic mix_acc;
        logic mix_wr_n;
        logic mix_wr_acc;
    } rc4_cmd_t;

    typedef struct packed {
        logic n_last;
        logic out_free;
    } rc4_status_t;

endpackage

>>> hw/rtl/rc4_ram.sv
module rc4_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 256
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

>>> hw/rtl/rc4_datapath.sv
module rc4_datapath import rc4_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  rc4_cmd_t          cmd,
    output rc4_status_t       status,
    input  logic [BYTE_W-1:0] value,
    input  logic              last,
    output logic [BYTE_W-1:0] data_out,
    output logic              last_out,
    output logic              result_valid,
    input  logic              result_ready
);

    logic [ADDR_W-1:0]    i_reg, j_reg, n_reg, k_reg, acc_reg;
    logic [ADDR_W-1:0]    j1_reg, t_reg;
    logic [BYTE_W-1:0]    a_reg, b_reg, si_reg;
    logic [BYTE_W-1:0]    value_reg;
    logic                 last_reg;
    logic [KEY_CNT_W-1:0] cnt_reg;
    logic [BYTE_W-1:0]    data_out_reg;
    logic                 last_out_reg;
    logic                 out_valid_reg;

    logic [BYTE_W-1:0]    sbox_rdata, key_rdata;
    logic [ADDR_W-1:0]    sbox_raddr, sbox_waddr;
    logic [BYTE_W-1:0]    sbox_wdata;
    logic                 sbox_we;
    logic                 key_we;

    logic [ADDR_W-1:0]    i1;
    logic [ADDR_W-1:0]    j_sum, t_sum, acc_mix;
    logic [BYTE_W-1:0]    ks;
    logic [KEY_CNT_W-1:0] k_inc;
    logic [ADDR_W-1:0]    k_wrap;

    assign i1      = i_reg + ADDR_W'(1);
    assign j_sum   = j_reg + sbox_rdata;
    assign t_sum   = a_reg + sbox_rdata;
    assign acc_mix = acc_reg + sbox_rdata + key_rdata;
    assign k_inc   = {1'b0, k_reg} + KEY_CNT_W'(1);
    assign k_wrap  = (k_inc >= cnt_reg) ? '0 : k_inc[ADDR_W-1:0];

    // forward the swap writes that the keystream read may have missed
    always_comb
    begin
        priority if (t_reg == j1_reg)
        begin
            ks = a_reg;
        end
        else if (t_reg == i1)
        begin
            ks = b_reg;
        end
        else
        begin
            ks = sbox_rdata;
        end
    end

    always_comb
    begin
        priority if (cmd.data_rd_j)
        begin
            sbox_raddr = j_sum;
        end
        else if (cmd.data_swap)
        begin
            sbox_raddr = t_sum;
        end
        else if (cmd.data_ks)
        begin
            sbox_raddr = t_reg;
        end
        else if (cmd.mix_acc)
        begin
            sbox_raddr = acc_mix;
        end
        else if (cmd.mix_rd)
        begin
            sbox_raddr = n_reg;
        end
        else
        begin
            sbox_raddr = i1;
        end
    end

    always_comb
    begin
        sbox_we = cmd.init_step | cmd.mix_wr_n | cmd.mix_wr_acc
                | cmd.data_swap | cmd.data_fin;
        priority if (cmd.mix_wr_n)
        begin
            sbox_waddr = n_reg;
            sbox_wdata = sbox_rdata;
        end
        else if (cmd.mix_wr_acc)
        begin
            sbox_waddr = acc_reg;
            sbox_wdata = si_reg;
        end
        else if (cmd.data_swap)
        begin
            sbox_waddr = i1;
            sbox_wdata = sbox_rdata;
        end
        else if (cmd.data_fin)
        begin
            sbox_waddr = j1_reg;
            sbox_wdata = a_reg;
        end
        else
        begin
            sbox_waddr = n_reg;
            sbox_wdata = BYTE_W'(n_reg);
        end
    end

    assign key_we = cmd.key_accept && (cnt_reg < KEY_CNT_W'(KEY_BYTES));

    rc4_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (SBOX_SIZE)
    ) u_sbox_ram (
        .clk   (clk),
        .we    (sbox_we),
        .waddr (sbox_waddr),
        .wdata (sbox_wdata),
        .raddr (sbox_raddr),
        .rdata (sbox_rdata)
    );

    rc4_ram #(
        .WIDTH (BYTE_W),
        .DEPTH (SBOX_SIZE)
    ) u_key_ram (
        .clk   (clk),
        .we    (key_we),
        .waddr (cnt_reg[ADDR_W-1:0]),
        .wdata (value),
        .raddr (k_reg),
        .rdata (key_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            i_reg         <= '0;
            j_reg         <= '0;
            n_reg         <= '0;
            k_reg         <= '0;
            acc_reg       <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.init_step)
            begin
                n_reg <= n_reg + ADDR_W'(1);
            end
            if (key_we)
            begin
                cnt_reg <= cnt_reg + KEY_CNT_W'(1);
            end
            if (cmd.sched_start)
            begin
                acc_reg <= '0;
                k_reg   <= '0;
            end
            if (cmd.mix_acc)
            begin
                acc_reg <= acc_mix;
            end
            if (cmd.mix_wr_acc)
            begin
                n_reg <= n_reg + ADDR_W'(1);
                k_reg <= k_wrap;
                if (status.n_last)
                begin
                    i_reg   <= '0;
                    j_reg   <= '0;
                    cnt_reg <= '0;
                end
            end
            if (cmd.data_fin)
            begin
                i_reg         <= i1;
                j_reg         <= j1_reg;
                out_valid_reg <= 1'b1;
            end
            else if (result_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.data_accept)
        begin
            value_reg <= value;
            last_reg  <= last;
        end
        if (cmd.data_rd_j)
        begin
            a_reg  <= sbox_rdata;
            j1_reg <= j_sum;
        end
        if (cmd.data_swap)
        begin
            b_reg <= sbox_rdata;
            t_reg <= t_sum;
        end
        if (cmd.mix_acc)
        begin
            si_reg <= sbox_rdata;
        end
        if (cmd.data_fin)
        begin
            data_out_reg <= value_reg ^ ks;
            last_out_reg <= last_reg;
        end
    end

    assign status.n_last   = (n_reg == ADDR_W'(SBOX_SIZE - 1));
    assign status.out_free = !out_valid_reg || result_ready;

    assign data_out     = data_out_reg;
    assign last_out     = last_out_reg;
    assign result_valid = out_valid_reg;

endmodule

>>> hw/rtl/rc4_controller.sv
module rc4_controller import rc4_pkg::*; (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    input  logic        mode,
    input  logic        last,
    input  rc4_status_t status,
    output logic        item_ready,
    output rc4_cmd_t    cmd
);

    rc4_state_t state_reg, state_next;
    logic       pending_reg, pending_next;

    always_comb
    begin
        cmd          = '0;
        state_next   = state_reg;
        pending_next = pending_reg;
        unique case (state_reg)
            ST_INIT:
            begin
                cmd.init_step = 1'b1;
                if (status.n_last)
                begin
                    if (pending_reg)
                    begin
                        state_next   = ST_M0;
                        pending_next = 1'b0;
                    end
                    else
                    begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_IDLE:
            begin
                if (item_valid)
                begin
                    if (mode)
                    begin
                        cmd.data_accept = 1'b1;
                        state_next      = ST_DJ;
                    end
                    else
                    begin
                        cmd.key_accept = 1'b1;
                        if (last)
                        begin
                            cmd.sched_start = 1'b1;
                            pending_next    = 1'b1;
                            state_next      = ST_INIT;
                        end
                    end
                end
            end
            ST_DJ:
            begin
                cmd.data_rd_j = 1'b1;
                state_next    = ST_DSW;
            end
            ST_DSW:
            begin
                cmd.data_swap = 1'b1;
                state_next    = ST_DKS;
            end
            ST_DKS:
            begin
                cmd.data_ks = 1'b1;
                if (status.out_free)
                begin
                    cmd.data_fin = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            ST_M0:
            begin
                cmd.mix_rd = 1'b1;
                state_next = ST_M1;
            end
            ST_M1:
            begin
                cmd.mix_acc = 1'b1;
                state_next  = ST_M2;
            end
            ST_M2:
            begin
                cmd.mix_wr_n = 1'b1;
                state_next   = ST_M3;
            end
            ST_M3:
            begin
                cmd.mix_wr_acc = 1'b1;
                state_next     = status.n_last ? ST_IDLE : ST_M0;
            end
            default:
            begin
                state_next = ST_INIT;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_INIT;
            pending_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            pending_reg <= pending_next;
        end
    end

    assign item_ready = (state_reg == ST_IDLE);

endmodule

>>> hw/rtl/rc4_stream_cipher.sv
// RC4 byte stream cipher. Send key bytes with mode 0, the final one with last set; bytes
// beyond KEY_BYTES are dropped. After reset the block fills the S-box with the identity
// (item_ready low). The last key byte starts the key schedule: an identity fill of all
// 256 entries, then 256 mixing steps through ST_M0 to ST_M3 (item_ready low). A key byte
// gives no result. A data byte (mode 1) passes through ST_DJ, ST_DSW and ST_DKS before
// the next possible transfer, set by the three dependent reads of the S-box through its
// single read port, and waits in ST_DKS while the previous result is not yet taken. Its
// result, data XOR keystream with last echoed, sits in an output register while the next item is taken.
module rc4_stream_cipher import rc4_pkg::*; (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_ready,
    input  logic              mode,
    input  logic [BYTE_W-1:0] value,
    input  logic              last,
    output logic              result_valid,
    input  logic              result_ready,
    output logic [BYTE_W-1:0] data_out,
    output logic              last_out
);

    rc4_cmd_t    cmd;
    rc4_status_t status;

    rc4_controller u_controller (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .mode       (mode),
        .last       (last),
        .status     (status),
        .item_ready (item_ready),
        .cmd        (cmd)
    );

    rc4_datapath u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .status       (status),
        .value        (value),
        .last         (last),
        .data_out     (data_out),
        .last_out     (last_out),
        .result_valid (result_valid),
        .result_ready (result_ready)
    );

endmodule

>>> hw/rtl/rc4_sva.sv
module rc4_sva (
    input logic       clk,
    input logic       rst_n,
    input logic       item_valid,
    input logic       item_ready,
    input logic       mode,
    input logic       result_valid,
    input logic       result_ready,
    input logic [7:0] data_out
);

    logic item_xfer;

    assign item_xfer = item_valid && item_ready;

    assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result_ready |=> result_valid && $stable(data_out))
    else $error("result dropped or changed while stalled");

    assert property (@(posedge clk) disable iff (!rst_n)
        item_xfer && mode |=> !item_ready)
    else $error("data byte followed by a transfer in the next cycle");

    assert property (@(posedge clk) disable iff (!rst_n)
        item_xfer && mode && !result_valid |=> ##3 result_valid)
    else $error("data byte result late");

    assert property (@(posedge clk) disable iff (!rst_n)
        item_xfer && !mode && !result_valid |=> !result_valid)
    else $error("key byte produced a result");

endmodule

bind rc4_stream_cipher rc4_sva u_rc4_sva (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_valid   (item_valid),
    .item_ready   (item_ready),
    .mode         (mode),
    .result_valid (result_valid),
    .result_ready (result_ready),
    .data_out     (data_out)
);
